[sv/aam_pkg.sv]
// ============================================================================
// aam_pkg
// Shared constants and types for the streaming argmax-along-axis block.
// ============================================================================
`default_nettype none

package aam_pkg;

    localparam int DATA_W     = 32;
    localparam int INNER_MAX  = 1024;
    localparam int AXIS_MAX   = 65536;
    localparam int SLOT_W     = $clog2(INNER_MAX);
    localparam int AXIS_W     = $clog2(AXIS_MAX);
    localparam int ALEN_W     = AXIS_W + 1;
    localparam int ILEN_W     = SLOT_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ALEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE  = 2'd2;

    localparam int MQ_DEPTH   = 4;
    localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W   = $clog2(MQ_DEPTH + 1);

    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [SLOT_W-1:0] slot;
        logic [AXIS_W-1:0] axis;
        logic              first;
        logic              last;
        logic              slice_end;
    } item_t;

    typedef struct packed {
        logic [AXIS_W-1:0] index;
        logic [DATA_W-1:0] value;
        logic              slice_end;
    } result_t;

    typedef struct packed {
        logic                busy;
        logic [OQ_CNT_W-1:0] oq_count;
    } bk_status_t;

endpackage

`default_nettype wire

[sv/aam_front.sv]
// ============================================================================
// aam_front
// Config registers, axis/inner position counters and word classification.
// ============================================================================
`default_nettype none

module aam_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [aam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [aam_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              accept,
    input  wire logic [aam_pkg::DATA_W-1:0]        element_value,
    output aam_pkg::item_t                         item,
    output logic                                   signed_mode
);

    logic [aam_pkg::AXIS_W-1:0] alen_m1_reg, alen_m1_next;
    logic [aam_pkg::SLOT_W-1:0] ilen_m1_reg, ilen_m1_next;
    logic                       signed_reg, signed_next;
    logic [aam_pkg::AXIS_W-1:0] axis_cnt_reg, axis_cnt_next;
    logic [aam_pkg::SLOT_W-1:0] inner_cnt_reg, inner_cnt_next;
    logic [aam_pkg::ALEN_W-1:0] alen_raw;
    logic [aam_pkg::ILEN_W-1:0] ilen_raw;
    logic                       cfg_hit;
    logic                       inner_wrap;
    logic                       axis_wrap;

    assign alen_raw = cfg_data;
    assign ilen_raw = cfg_data[aam_pkg::ILEN_W-1:0];

    always_comb
    begin
        alen_m1_next = alen_m1_reg;
        ilen_m1_next = ilen_m1_reg;
        signed_next  = signed_reg;
        cfg_hit      = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                aam_pkg::REG_AXIS_LENGTH:
                begin
                    cfg_hit = 1'b1;
                    if (alen_raw == '0)
                        alen_m1_next = '0;
                    else if (alen_raw > aam_pkg::ALEN_W'(aam_pkg::AXIS_MAX))
                        alen_m1_next = aam_pkg::AXIS_W'(aam_pkg::AXIS_MAX - 1);
                    else
                        alen_m1_next = aam_pkg::AXIS_W'(alen_raw - 1'b1);
                end
                aam_pkg::REG_INNER_STRIDE:
                begin
                    cfg_hit = 1'b1;
                    if (ilen_raw == '0)
                        ilen_m1_next = '0;
                    else if (ilen_raw > aam_pkg::ILEN_W'(aam_pkg::INNER_MAX))
                        ilen_m1_next = aam_pkg::SLOT_W'(aam_pkg::INNER_MAX - 1);
                    else
                        ilen_m1_next = aam_pkg::SLOT_W'(ilen_raw - 1'b1);
                end
                aam_pkg::REG_SIGNED_MODE:
                begin
                    cfg_hit     = 1'b1;
                    signed_next = cfg_data[0];
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign inner_wrap = (inner_cnt_reg == ilen_m1_reg);
    assign axis_wrap  = (axis_cnt_reg == alen_m1_reg);

    always_comb
    begin
        inner_cnt_next = inner_cnt_reg;
        axis_cnt_next  = axis_cnt_reg;
        if (cfg_hit)
        begin
            inner_cnt_next = '0;
            axis_cnt_next  = '0;
        end
        else if (accept)
        begin
            if (inner_wrap)
            begin
                inner_cnt_next = '0;
                axis_cnt_next  = axis_wrap ? '0 : axis_cnt_reg + 1'b1;
            end
            else
            begin
                inner_cnt_next = inner_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alen_m1_reg   <= '0;
            ilen_m1_reg   <= '0;
            signed_reg    <= 1'b1;
            axis_cnt_reg  <= '0;
            inner_cnt_reg <= '0;
        end
        else
        begin
            alen_m1_reg   <= alen_m1_next;
            ilen_m1_reg   <= ilen_m1_next;
            signed_reg    <= signed_next;
            axis_cnt_reg  <= axis_cnt_next;
            inner_cnt_reg <= inner_cnt_next;
        end
    end

    always_comb
    begin
        item.value     = element_value;
        item.slot      = inner_cnt_reg;
        item.axis      = axis_cnt_reg;
        item.first     = (axis_cnt_reg == '0);
        item.last      = axis_wrap;
        item.slice_end = inner_wrap;
    end

    assign signed_mode = signed_reg;

endmodule

`default_nettype wire

[sv/aam_mid_queue.sv]
// ============================================================================
// aam_mid_queue
// Short queue of classified words between front and back.
// ============================================================================
`default_nettype none

module aam_mid_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire aam_pkg::item_t push_item,
    output logic                full,
    output logic                valid,
    output aam_pkg::item_t      head,
    input  wire logic           pop
);

    aam_pkg::item_t                 q_mem [aam_pkg::MQ_DEPTH];
    logic [aam_pkg::MQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [aam_pkg::MQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [aam_pkg::MQ_CNT_W-1:0]   count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == aam_pkg::MQ_CNT_W'(aam_pkg::MQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign head    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == aam_pkg::MQ_PTR_W'(aam_pkg::MQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == aam_pkg::MQ_PTR_W'(aam_pkg::MQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[sv/aam_back.sv]
// ============================================================================
// aam_back
// Best-value table read-compare-write with bypass, and result queue.
// ============================================================================
`default_nettype none

module aam_back
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      signed_mode,
    input  wire logic                      mid_valid,
    input  wire aam_pkg::item_t            mid_head,
    output logic                           mid_pop,
    output logic                           empty,
    input  wire logic                      pop,
    output aam_pkg::result_t               result,
    output aam_pkg::bk_status_t            status
);

    logic [aam_pkg::DATA_W-1:0] val_mem [aam_pkg::INNER_MAX];
    logic [aam_pkg::AXIS_W-1:0] idx_mem [aam_pkg::INNER_MAX];

    logic                       b_valid_reg, b_valid_next;
    aam_pkg::item_t             b_item_reg;
    logic [aam_pkg::DATA_W-1:0] rd_value_reg;
    logic [aam_pkg::AXIS_W-1:0] rd_index_reg;

    logic                       fwd_valid_reg;
    logic [aam_pkg::SLOT_W-1:0] fwd_slot_reg;
    logic [aam_pkg::DATA_W-1:0] fwd_value_reg;
    logic [aam_pkg::AXIS_W-1:0] fwd_index_reg;

    logic [aam_pkg::DATA_W-1:0] old_value;
    logic [aam_pkg::AXIS_W-1:0] old_index;
    logic [aam_pkg::DATA_W-1:0] sign_flip;
    logic                       greater;
    logic [aam_pkg::DATA_W-1:0] new_value;
    logic [aam_pkg::AXIS_W-1:0] new_index;

    aam_pkg::result_t             oq_mem [aam_pkg::OQ_DEPTH];
    logic [aam_pkg::OQ_PTR_W-1:0] oq_wr_reg, oq_wr_next;
    logic [aam_pkg::OQ_PTR_W-1:0] oq_rd_reg, oq_rd_next;
    logic [aam_pkg::OQ_CNT_W-1:0] oq_cnt_reg, oq_cnt_next;
    logic                         oq_push;
    logic                         oq_pop;
    aam_pkg::result_t             oq_word;

    // issue only when the result queue can absorb everything in flight
    assign mid_pop = mid_valid &&
        (({1'b0, oq_cnt_reg} + {{aam_pkg::OQ_CNT_W{1'b0}}, b_valid_reg})
         < (aam_pkg::OQ_CNT_W + 1)'(aam_pkg::OQ_DEPTH));
    assign b_valid_next = mid_pop;

    // bypass the write committed on the same edge as this word's read
    always_comb
    begin
        if (fwd_valid_reg && (fwd_slot_reg == b_item_reg.slot))
        begin
            old_value = fwd_value_reg;
            old_index = fwd_index_reg;
        end
        else
        begin
            old_value = rd_value_reg;
            old_index = rd_index_reg;
        end
    end

    assign sign_flip = {signed_mode, {(aam_pkg::DATA_W - 1){1'b0}}};
    assign greater   = (b_item_reg.value ^ sign_flip) > (old_value ^ sign_flip);

    always_comb
    begin
        if (b_item_reg.first || greater)
        begin
            new_value = b_item_reg.value;
            new_index = b_item_reg.first ? '0 : b_item_reg.axis;
        end
        else
        begin
            new_value = old_value;
            new_index = old_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            val_mem[b_item_reg.slot] <= new_value;
            idx_mem[b_item_reg.slot] <= new_index;
        end
        if (mid_pop)
        begin
            rd_value_reg <= val_mem[mid_head.slot];
            rd_index_reg <= idx_mem[mid_head.slot];
            b_item_reg   <= mid_head;
        end
        fwd_slot_reg  <= b_item_reg.slot;
        fwd_value_reg <= new_value;
        fwd_index_reg <= new_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            fwd_valid_reg <= b_valid_reg;
        end
    end

    // result queue
    assign oq_push         = b_valid_reg && b_item_reg.last;
    assign empty           = (oq_cnt_reg == '0);
    assign oq_pop          = pop && !empty;
    assign oq_word.index     = new_index;
    assign oq_word.value     = new_value;
    assign oq_word.slice_end = b_item_reg.slice_end;
    assign result          = oq_mem[oq_rd_reg];

    always_comb
    begin
        oq_wr_next  = oq_wr_reg;
        oq_rd_next  = oq_rd_reg;
        oq_cnt_next = oq_cnt_reg;
        if (oq_push)
            oq_wr_next = (oq_wr_reg == aam_pkg::OQ_PTR_W'(aam_pkg::OQ_DEPTH - 1))
                         ? '0 : oq_wr_reg + 1'b1;
        if (oq_pop)
            oq_rd_next = (oq_rd_reg == aam_pkg::OQ_PTR_W'(aam_pkg::OQ_DEPTH - 1))
                         ? '0 : oq_rd_reg + 1'b1;
        if (oq_push && !oq_pop)
            oq_cnt_next = oq_cnt_reg + 1'b1;
        else if (oq_pop && !oq_push)
            oq_cnt_next = oq_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_reg] <= oq_word;
    end

    assign status.busy     = b_valid_reg;
    assign status.oq_count = oq_cnt_reg;

endmodule

`default_nettype wire

[sv/axis_argmax_with_value_top.sv]
// ============================================================================
// axis_argmax_with_value_top
// Streaming argmax with value along one tensor axis.
//
// channel   | handshake          | word
// ----------+--------------------+----------------------------------------
// config    | cfg_we             | cfg_index, cfg_data
// input     | push / full        | element_value
// result    | pop / empty        | max_index, max_value, slice_end
//
// One word per cycle sustained while results are popped; the 1024-entry
// best-value table does one read and one write per cycle, with a bypass for
// back-to-back slot reuse. Tables need no clearing after reset; a config
// write to a defined register restarts counters. Input and result sides
// stall independently through two 4-word queues.
// ============================================================================
`default_nettype none

module axis_argmax_with_value_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [aam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [aam_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [aam_pkg::DATA_W-1:0]     element_value,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [aam_pkg::AXIS_W-1:0]          max_index,
    output logic [aam_pkg::DATA_W-1:0]          max_value,
    output logic                                slice_end
);

    aam_pkg::item_t      front_item;
    aam_pkg::item_t      mid_head;
    aam_pkg::result_t    result;
    aam_pkg::bk_status_t bk_status;
    logic                accept;
    logic                signed_mode;
    logic                mid_valid;
    logic                mid_pop;

    assign accept = push && !full;

    aam_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .element_value (element_value),
        .item          (front_item),
        .signed_mode   (signed_mode)
    );

    aam_mid_queue u_mid_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .valid     (mid_valid),
        .head      (mid_head),
        .pop       (mid_pop)
    );

    aam_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .signed_mode (signed_mode),
        .mid_valid   (mid_valid),
        .mid_head    (mid_head),
        .mid_pop     (mid_pop),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .status      (bk_status)
    );

    assign max_index = result.index;
    assign max_value = result.value;
    assign slice_end = result.slice_end;

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.oq_count <= aam_pkg::OQ_CNT_W'(aam_pkg::OQ_DEPTH))
        else $error("result queue overflow");

    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |=> bk_status.busy)
        else $error("issued word not in back stage");

    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_status.oq_count == '0) == empty)
        else $error("empty flag disagrees with result count");
`endif

endmodule

`default_nettype wire
